### rtl/kped_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key press event detector.
// No dependencies; used by kped_fsm, kped_fifo and the top level.
package kped_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CODE_W      = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CODE_W-1:0] NULL_CODE = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_REPEAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_CODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE      = 3'd6;

  typedef struct packed {
    logic [7:0]        filter_time;
    logic [15:0]       long_time;
    logic [7:0]        repeat_speed;
    logic [7:0]        hold_before_repeat;
    logic [CODE_W-1:0] down_code;
    logic [CODE_W-1:0] long_code;
    logic [CODE_W-1:0] up_code;
  } cfg_t;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] code;
  } push_t;

endpackage

### rtl/kped_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kped_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kped_fsm.sv
`timescale 1ns / 1ps
// Configuration registers and the debounce / long press / repeat state machine.
// Depends on kped_pkg; emits at most one push request per tick to the event queue.
module kped_fsm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kped_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kped_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             tick_i,
  input  logic                             key_down_i,
  output kped_pkg::push_t                  push_o
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_HOLD     = 3'd2,
    ST_REPEAT   = 3'd3,
    ST_RELEASE  = 3'd4
  } state_e;

  kped_pkg::cfg_t cfg_q;
  state_e         state_q, state_d;
  logic [7:0]     filt_q, filt_d, filt_inc;
  logic [15:0]    hold_q, hold_d, hold_inc, hold_limit;
  logic           filt_done, hold_done;
  kped_pkg::push_t push;

  assign filt_inc  = (filt_q == 8'hFF) ? 8'hFF : filt_q + 8'd1;
  assign filt_done = filt_inc >= cfg_q.filter_time;
  assign hold_inc  = (hold_q == 16'hFFFF) ? 16'hFFFF : hold_q + 16'd1;

  always_comb begin
    if (state_q == ST_HOLD && cfg_q.long_time != 16'd0) begin
      hold_limit = cfg_q.long_time;
    end else if (state_q == ST_HOLD) begin
      hold_limit = {8'h00, cfg_q.hold_before_repeat};
    end else begin
      hold_limit = {8'h00, cfg_q.repeat_speed};
    end
  end

  assign hold_done = hold_inc >= hold_limit;

  always_comb begin
    state_d   = state_q;
    filt_d    = filt_q;
    hold_d    = hold_q;
    push.push = 1'b0;
    push.code = cfg_q.down_code;
    case (state_q)
      ST_IDLE: begin
        if (key_down_i) state_d = ST_DEBOUNCE;
      end
      ST_DEBOUNCE: begin
        filt_d = filt_done ? 8'd0 : filt_inc;
        if (filt_done) begin
          if (!key_down_i) begin
            state_d = ST_IDLE;
          end else if (cfg_q.long_time == 16'd0 && cfg_q.repeat_speed == 8'd0) begin
            push.push = 1'b1;
            state_d   = ST_RELEASE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (cfg_q.long_time != 16'd0) begin
          if (key_down_i) begin
            hold_d = hold_done ? 16'd0 : hold_inc;
            if (hold_done) begin
              push.push = 1'b1;
              push.code = cfg_q.long_code;
              state_d   = (cfg_q.repeat_speed == 8'd0) ? ST_RELEASE : ST_REPEAT;
            end
          end else begin
            push.push = 1'b1;
            hold_d    = 16'd0;
            state_d   = ST_RELEASE;
          end
        end else if (cfg_q.repeat_speed != 8'd0) begin
          if (key_down_i) begin
            hold_d = hold_done ? 16'd0 : hold_inc;
            if (hold_done) state_d = ST_REPEAT;
          end else begin
            push.push = 1'b1;
            hold_d    = 16'd0;
            state_d   = ST_RELEASE;
          end
        end else begin
          push.push = 1'b1;
          state_d   = ST_RELEASE;
        end
      end
      ST_REPEAT: begin
        if (cfg_q.repeat_speed != 8'd0 && key_down_i) begin
          hold_d = hold_done ? 16'd0 : hold_inc;
          if (hold_done) push.push = 1'b1;
        end else begin
          hold_d  = 16'd0;
          state_d = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        filt_d = filt_done ? 8'd0 : filt_inc;
        if (filt_done && !key_down_i) begin
          push.push = (cfg_q.up_code != kped_pkg::NULL_CODE);
          push.code = cfg_q.up_code;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign push_o.push = tick_i && push.push;
  assign push_o.code = push.code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                  <= ST_IDLE;
      filt_q                   <= 8'd0;
      hold_q                   <= 16'd0;
      cfg_q.filter_time        <= 8'd5;
      cfg_q.long_time          <= 16'd0;
      cfg_q.repeat_speed       <= 8'd0;
      cfg_q.hold_before_repeat <= 8'd50;
      cfg_q.down_code          <= 8'd1;
      cfg_q.long_code          <= 8'd2;
      cfg_q.up_code            <= 8'd0;
    end else begin
      if (tick_i) begin
        state_q <= state_d;
        filt_q  <= filt_d;
        hold_q  <= hold_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          kped_pkg::CFG_FILTER_TIME:  cfg_q.filter_time        <= cfg_wdata_i[7:0];
          kped_pkg::CFG_LONG_TIME:    cfg_q.long_time          <= cfg_wdata_i;
          kped_pkg::CFG_REPEAT_SPEED: cfg_q.repeat_speed       <= cfg_wdata_i[7:0];
          kped_pkg::CFG_HOLD_REPEAT:  cfg_q.hold_before_repeat <= cfg_wdata_i[7:0];
          kped_pkg::CFG_DOWN_CODE:    cfg_q.down_code          <= cfg_wdata_i[7:0];
          kped_pkg::CFG_LONG_CODE:    cfg_q.long_code          <= cfg_wdata_i[7:0];
          kped_pkg::CFG_UP_CODE:      cfg_q.up_code            <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### rtl/kped_fifo.sv
`timescale 1ns / 1ps
// Circular event queue: pointers and fill count around one event RAM.
// Depends on kped_pkg and kped_ram.
module kped_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kped_pkg::push_t             push_i,
  input  logic                        pop_i,
  output logic                        dropped_o,
  output logic                        hit_o,
  output logic [kped_pkg::CODE_W-1:0] rdata_o
);

  logic [kped_pkg::PTR_W-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [kped_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       full, empty, we, re;

  assign full      = (cnt_q == kped_pkg::CNT_W'(kped_pkg::QUEUE_DEPTH));
  assign empty     = (cnt_q == '0);
  assign we        = push_i.push && !full;
  assign re        = pop_i && !empty;
  assign dropped_o = push_i.push && full;
  assign hit_o     = re;

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (we) begin
      wr_d  = (wr_q == kped_pkg::PTR_W'(kped_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end else if (re) begin
      rd_d  = (rd_q == kped_pkg::PTR_W'(kped_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  kped_ram #(
    .WIDTH(kped_pkg::CODE_W),
    .DEPTH(kped_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_q),
    .wdata_i (push_i.code),
    .re_i    (re),
    .raddr_i (rd_q),
    .rdata_o (rdata_o)
  );

endmodule

### rtl/key_press_event_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the key press event detector: input channel, result pipeline.
// Depends on kped_pkg, kped_fsm and kped_fifo.
//
// Input channel (in_valid_i / in_stall_o): each word is a tick carrying one
// key sample (operation_i = 0) or a pop request (operation_i = 1).
// Output channel (out_valid_o / out_stall_i): exactly one word per input
// word, in order: event_code_o, event_valid_o, event_dropped_o. A tick
// returns the null code with event_dropped_o set if its event found the
// 16-entry queue full; a pop returns the oldest event, or the null code
// with event_valid_o low when the queue is empty.
// Each accepted word passes through the event RAM read stage and then the
// output register to out_valid_o. One word is accepted every cycle while
// in_stall_o is low; state is updated at acceptance, so the next word sees
// it at once. When the receiver stalls, the output register and the RAM
// read stage hold their words; the input stalls once both are full.
// Reset returns the detector to idle, empties the queue and loads the
// register defaults; the event RAM itself is not cleared.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) is to be written by the user
// only while the block is idle; the block itself does not enforce this.
module key_press_event_detector_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic                             key_down_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kped_pkg::CODE_W-1:0]      event_code_o,
  output logic                             event_valid_o,
  output logic                             event_dropped_o,
  input  logic                             cfg_we_i,
  input  logic [kped_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kped_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  kped_pkg::push_t             push;
  logic                        accept, out_ready, s1_move;
  logic                        hit, dropped;
  logic [kped_pkg::CODE_W-1:0] rdata;
  logic                        s1_valid_q, s1_hit_q, s1_drop_q;
  logic                        out_valid_q, out_evalid_q, out_drop_q;
  logic [kped_pkg::CODE_W-1:0] out_code_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_move    = s1_valid_q && out_ready;

  kped_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (accept && !operation_i),
    .key_down_i  (key_down_i),
    .push_o      (push)
  );

  kped_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (accept && operation_i),
    .dropped_o (dropped),
    .hit_o     (hit),
    .rdata_o   (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !out_ready);
      if (out_ready) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hit_q  <= hit;
      s1_drop_q <= dropped;
    end
    if (s1_move) begin
      out_code_q   <= s1_hit_q ? rdata : kped_pkg::NULL_CODE;
      out_evalid_q <= s1_hit_q;
      out_drop_q   <= s1_drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = out_code_q;
  assign event_valid_o   = out_evalid_q;
  assign event_dropped_o = out_drop_q;

`ifndef SYNTHESIS
  a_pop_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |-> !event_dropped_o)
    else $error("pop word flagged as dropped");

  a_null_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> event_code_o == kped_pkg::NULL_CODE)
    else $error("non-null code without a queued event");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && out_valid_q)
    else $error("word lost in result pipeline under stall");
`endif

endmodule
